// ===== rtl/udc_pkg.sv =====
// Shared constants, types and codes for the UTF-8 to code page decoder.
`default_nettype none

package udc_pkg;

    // Table geometry: the table is split over a row of identical search cells.
    localparam int TABLE_DEPTH  = 128;
    localparam int IDX_W        = 7;
    localparam int NUM_CELLS    = 16;
    localparam int CELL_ID_W    = 4;
    localparam int CELL_ENTRIES = 8;
    localparam int SUB_W        = 3;

    localparam int VALUE_W = 16;
    localparam int JOIN_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int SIX_W   = 6;

    localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
    } tbl_wr_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [JOIN_W-1:0] joined;
        logic              found;
        logic [IDX_W-1:0]  idx;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_out;
        logic              run_last;
        logic              end_of_text;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_codepage_decoder.sv =====
// Top level of the UTF-8 to single-byte code page decoder.
// A table write lands in the owning cell's entry register at the edge that accepts it; a text
// byte passes the launch register, the sixteen-cell search row and the finish state before its
// results enter the result queue. Table writes are taken one per cycle while idle; a text byte
// holds off all transfers until it has passed the row, one cell per cycle, and been queued.
// Reset: synchronous, active-low aresetn clears the whole code table, the held lead byte and
// the result queue; the block accepts transfers in the first cycle after reset.
`default_nettype none

module utf8_to_codepage_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // entry_index [6:0], entry_value [22:7],
                                        // text_byte [30:23], zero [31]
    input  wire logic        s_tuser,   // opcode: 0 writes a table entry, 1 decodes a byte
    input  wire logic        s_tlast,   // text_last
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // char_out [7:0]
    output logic             m_tuser,   // run_last
    output logic             m_tlast    // end_of_text
);

    // Control state.
    udc_pkg::state_t  state_reg, state_next;
    udc_pkg::token_t  launch_reg, launch_next;
    udc_pkg::token_t  chain_out;
    udc_pkg::tbl_wr_t tbl_wr;

    // Item being decoded and the outcome of its table search.
    logic [udc_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       found_reg, found_next;
    logic [udc_pkg::IDX_W-1:0]  hit_idx_reg, hit_idx_next;

    // Lead byte waiting for its partner.
    logic [udc_pkg::BYTE_W-1:0] held_lead_reg, held_lead_next;
    logic                       held_valid_reg, held_valid_next;

    // Two-entry result queue; entry 0 is presented on the result channel.
    udc_pkg::result_t q_reg [2];
    udc_pkg::result_t q_next [2];
    logic [1:0]       q_cnt_reg, q_cnt_next;
    logic [1:0]       cnt_after_pop;

    udc_pkg::result_t res [2];
    logic [1:0]       res_n;
    logic             hold;
    logic             room;
    logic             push_go;
    logic             s_accept;
    logic             m_accept;

    assign s_tready = (state_reg == udc_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_accept = m_tvalid && m_tready;

    assign m_tdata = q_reg[0].char_out;
    assign m_tuser = q_reg[0].run_last;
    assign m_tlast = q_reg[0].end_of_text;

    // Table writes are broadcast to every cell; the owning cell picks them up.
    assign tbl_wr.en    = s_accept && (s_tuser == udc_pkg::OP_WRITE);
    assign tbl_wr.idx   = s_tdata[6:0];
    assign tbl_wr.value = s_tdata[22:7];

    udc_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .tok_in  (launch_reg),
        .tok_out (chain_out)
    );

    // Work out the results of the finished item. A held lead byte either pairs with this
    // byte to form a table match, or falls out as a space before the byte is handled alone.
    always_comb begin
        res[0] = '0;
        res[1] = '0;
        res_n  = 2'd0;
        hold   = 1'b0;
        if (held_valid_reg && found_reg) begin
            res[0] = '{char_out: {1'b1, hit_idx_reg}, run_last: 1'b1, end_of_text: last_reg};
            res_n  = 2'd1;
        end else begin
            if (held_valid_reg) begin
                res[0] = '{char_out: udc_pkg::SPACE_CODE, run_last: 1'b0, end_of_text: 1'b0};
                res_n  = 2'd1;
            end
            if (!byte_reg[udc_pkg::BYTE_W-1]) begin
                res[res_n[0]] = '{char_out: byte_reg, run_last: 1'b1, end_of_text: last_reg};
                res_n = res_n + 2'd1;
            end else if (last_reg) begin
                // An upper byte at the end of the text cannot be held.
                res[res_n[0]] = '{char_out: udc_pkg::SPACE_CODE, run_last: 1'b1,
                                  end_of_text: 1'b1};
                res_n = res_n + 2'd1;
            end else begin
                hold = 1'b1;
                if (res_n != 2'd0) begin
                    res[0].run_last = 1'b1;
                end
            end
        end
    end

    assign room    = ({1'b0, q_cnt_reg} + {1'b0, res_n}) <= 3'd2;
    assign push_go = (state_reg == udc_pkg::ST_FINISH) && room;

    // Sequencer: accept, run the search row, then hand the results to the queue.
    always_comb begin
        state_next      = state_reg;
        launch_next     = '0;
        byte_next       = byte_reg;
        last_next       = last_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        held_lead_next  = held_lead_reg;
        held_valid_next = held_valid_reg;
        unique case (state_reg)
            udc_pkg::ST_IDLE: begin
                if (s_accept && (s_tuser == udc_pkg::OP_DECODE)) begin
                    byte_next          = s_tdata[30:23];
                    last_next          = s_tlast;
                    launch_next.valid  = 1'b1;
                    launch_next.joined = {held_lead_reg[udc_pkg::SIX_W-1:0],
                                          s_tdata[28:23]};
                    state_next         = udc_pkg::ST_SEARCH;
                end
            end
            udc_pkg::ST_SEARCH: begin
                if (chain_out.valid) begin
                    found_next   = chain_out.found;
                    hit_idx_next = chain_out.idx;
                    state_next   = udc_pkg::ST_FINISH;
                end
            end
            udc_pkg::ST_FINISH: begin
                if (room) begin
                    held_valid_next = hold;
                    held_lead_next  = hold ? byte_reg : '0;
                    state_next      = udc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = udc_pkg::ST_IDLE;
            end
        endcase
    end

    // Result queue: pop from the head, then append at the first free place.
    always_comb begin
        q_next[0]     = q_reg[0];
        q_next[1]     = q_reg[1];
        cnt_after_pop = q_cnt_reg;
        if (m_accept) begin
            q_next[0]     = q_reg[1];
            cnt_after_pop = q_cnt_reg - 2'd1;
        end
        q_cnt_next = cnt_after_pop;
        if (push_go) begin
            if (res_n != 2'd0) begin
                q_next[cnt_after_pop[0]] = res[0];
            end
            if (res_n == 2'd2) begin
                q_next[1] = res[1];
            end
            q_cnt_next = cnt_after_pop + res_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= udc_pkg::ST_IDLE;
            launch_reg     <= '0;
            held_lead_reg  <= '0;
            held_valid_reg <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end else begin
            state_reg      <= state_next;
            launch_reg     <= launch_next;
            held_lead_reg  <= held_lead_next;
            held_valid_reg <= held_valid_next;
            q_cnt_reg      <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        found_reg   <= found_next;
        hit_idx_reg <= hit_idx_next;
        q_reg[0]    <= q_next[0];
        q_reg[1]    <= q_next[1];
    end

    // A search result leaves the row only while the sequencer waits for it.
    a_chain_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.valid |-> state_reg == udc_pkg::ST_SEARCH)
        else $error("search result arrived outside the search phase");

    // The table never changes while a search is running.
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> state_reg == udc_pkg::ST_IDLE)
        else $error("table written during a search");

    // A byte that ends the text never leaves a lead byte held.
    a_no_hold_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_go && last_reg) |=> !held_valid_reg)
        else $error("lead byte held past the end of the text");

    // The queue never holds more than its two entries.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg != 2'd3)
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== rtl/udc_cell.sv =====
// One search cell: eight table entries and a registered compare stage.
`default_nettype none

module udc_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [udc_pkg::CELL_ID_W-1:0] cell_id,
    input  wire udc_pkg::tbl_wr_t              wr,
    input  wire udc_pkg::token_t               tok_in,
    output udc_pkg::token_t                    tok_out
);

    logic [udc_pkg::VALUE_W-1:0] entry_reg [udc_pkg::CELL_ENTRIES];
    udc_pkg::token_t             tok_reg;
    udc_pkg::token_t             tok_next;
    logic                        hit;
    logic [udc_pkg::SUB_W-1:0]   hit_sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < udc_pkg::CELL_ENTRIES; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr.en && wr.idx[udc_pkg::IDX_W-1:udc_pkg::SUB_W] == cell_id) begin
            entry_reg[wr.idx[udc_pkg::SUB_W-1:0]] <= wr.value;
        end
    end

    // The highest matching entry within the cell wins.
    always_comb begin
        hit     = 1'b0;
        hit_sub = '0;
        for (int i = 0; i < udc_pkg::CELL_ENTRIES; i++) begin
            if (entry_reg[i] == {{(udc_pkg::VALUE_W-udc_pkg::JOIN_W){1'b0}}, tok_in.joined})
            begin
                hit     = 1'b1;
                hit_sub = (udc_pkg::SUB_W)'(i);
            end
        end
        tok_next = tok_in;
        // Cells further down the row hold higher indices, so a later hit overrides.
        if (tok_in.valid && hit) begin
            tok_next.found = 1'b1;
            tok_next.idx   = {cell_id, hit_sub};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/udc_chain.sv =====
// Row of search cells that together hold the whole code table.
`default_nettype none

module udc_chain (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire udc_pkg::tbl_wr_t wr,
    input  wire udc_pkg::token_t  tok_in,
    output udc_pkg::token_t       tok_out
);

    udc_pkg::token_t tok [udc_pkg::NUM_CELLS+1];

    assign tok[0] = tok_in;

    for (genvar g = 0; g < udc_pkg::NUM_CELLS; g++) begin : g_cell
        udc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_id ((udc_pkg::CELL_ID_W)'(g)),
            .wr      (wr),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tok_out = tok[udc_pkg::NUM_CELLS];

endmodule

`default_nettype wire
